>>> rtl/vpa_pkg.sv
// vpa_pkg: shared types and constants for the vector polar angle block.
// Request/response payload structs, CORDIC arctangent table, widths.
// No dependencies.
package vpa_pkg;

   localparam int SAMPLE_BITS  = 24;
   localparam int ANGLE_BITS   = 16;
   localparam int BAND_BITS    = 10;
   localparam int CORDIC_STEPS = 31;
   // magnitudes are pre-scaled to put the MSB near bit 59
   localparam int PRESHIFT     = 60 - SAMPLE_BITS;
   // two guard bits cover the CORDIC gain and the sqrt(2) of the vector length
   localparam int CW           = SAMPLE_BITS + PRESHIFT + 2;
   // angle accumulator, units of 2^-32 turn, signed
   localparam int ZW           = 33;
   localparam int ROUND_DROP   = 32 - ANGLE_BITS;
   localparam int CMPW         = (SAMPLE_BITS > BAND_BITS) ? SAMPLE_BITS : BAND_BITS;
   // input register + one register per step + round + quadrant
   localparam int PIPE_LATENCY = CORDIC_STEPS + 3;

   typedef logic [31:0] atan_word_type;

   // atan(2^-i) in units of 2^-32 turn
   localparam atan_word_type ATAN_TABLE [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
      32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
      32'd1
   };

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x_coord;
      logic signed [SAMPLE_BITS-1:0] y_coord;
   } req_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] full_angle;
      logic [ANGLE_BITS-2:0] orientation;
   } rsp_type;

   // per-request flags that ride alongside the CORDIC datapath
   typedef struct packed {
      logic vertical;
      logic x_neg;
      logic y_neg;
   } side_type;

endpackage

>>> rtl/vpa_cordic_stage.sv
// vpa_cordic_stage: one registered CORDIC vectoring step (rotation STEP).
// Depends on vpa_pkg.
module vpa_cordic_stage #(
   parameter int STEP = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [vpa_pkg::CW-1:0] in_x,
   input  logic signed [vpa_pkg::CW-1:0] in_y,
   input  logic signed [vpa_pkg::ZW-1:0] in_z,
   input  vpa_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic signed [vpa_pkg::CW-1:0] out_x,
   output logic signed [vpa_pkg::CW-1:0] out_y,
   output logic signed [vpa_pkg::ZW-1:0] out_z,
   output vpa_pkg::side_type             out_side
);

   localparam logic signed [vpa_pkg::ZW-1:0] STEP_ANGLE =
      $signed({{(vpa_pkg::ZW-32){1'b0}}, vpa_pkg::ATAN_TABLE[STEP]});

   logic signed [vpa_pkg::CW-1:0] dx, dy;
   logic signed [vpa_pkg::CW-1:0] x_in, y_in, x_ff, y_ff;
   logic signed [vpa_pkg::ZW-1:0] z_in, z_ff;
   vpa_pkg::side_type             side_ff;
   logic                          valid_ff;

   // arithmetic shift is floor division by 2^STEP
   assign dx = in_y >>> STEP;
   assign dy = in_x >>> STEP;

   always_comb begin
      if (!in_y[vpa_pkg::CW-1]) begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + STEP_ANGLE;
      end else begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

>>> rtl/vector_polar_angle.sv
// vector_polar_angle: full-circle polar angle and orientation of a 2-D vector.
// Depends on vpa_pkg and vpa_cordic_stage.
//
// Usage:
//  - Request channel: drive req_payload (signed x_coord, y_coord) and pulse
//    start. A request is taken at any rising edge with start high and busy
//    low. busy is high only while reset is asserted; otherwise a new request
//    may be issued every cycle.
//  - Response channel: rsp_valid strobes for one cycle with rsp_payload
//    (full_angle, 65536 = 2pi; orientation, angle folded into [0, pi)).
//    The receiver must take it in that cycle; there is no hold-off.
//  - CSR: csr_we writes csr_wdata into the x zero band register (reset 0).
//    Any |x| at or below it counts as vertical: pi/2, or 3pi/2 for y < 0.
//    Write it only while no request is in flight.
//  - Pipeline: one input register (magnitudes, quadrant, vertical test),
//    31 CORDIC vectoring stages at one rotation per register, one
//    saturate/round stage and one quadrant placement stage. Throughput:
//    one request per cycle outside reset.
//  - Reset clears the band register and every valid bit, so requests in
//    flight are dropped and no strobe follows until new requests arrive.
module vector_polar_angle (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  vpa_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   output vpa_pkg::rsp_type               rsp_payload,
   input  logic                           csr_we,
   input  logic [vpa_pkg::BAND_BITS-1:0]  csr_wdata
);

   localparam int S  = vpa_pkg::SAMPLE_BITS;
   localparam int A  = vpa_pkg::ANGLE_BITS;
   localparam int N  = vpa_pkg::CORDIC_STEPS;
   localparam int CW = vpa_pkg::CW;
   localparam int ZW = vpa_pkg::ZW;

   // quarter turn in 2^-32 turn units: upper saturation bound
   localparam logic signed [ZW-1:0] Z_MAX = $signed(ZW'(64'd1 << 30));
   localparam logic [31:0] ROUND_HALF =
      (vpa_pkg::ROUND_DROP > 0) ? (32'd1 << (vpa_pkg::ROUND_DROP - 1)) : 32'd0;
   localparam logic [A-1:0] HALF_TURN    = A'(64'd1 << (A - 1));
   localparam logic [A-1:0] QUARTER_TURN = A'(64'd1 << (A - 2));

   // ---------------------------------------------------------------
   // CSR
   // ---------------------------------------------------------------
   logic [vpa_pkg::BAND_BITS-1:0] band_in, band_ff;

   assign band_in = csr_we ? csr_wdata : band_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff <= '0;
      end else begin
         band_ff <= band_in;
      end
   end

   // ---------------------------------------------------------------
   // Request accept; the pipeline never stalls
   // ---------------------------------------------------------------
   logic accept;

   assign busy   = reset;
   assign accept = start & ~busy;

   // ---------------------------------------------------------------
   // Input stage: magnitudes, sign flags, vertical test
   // ---------------------------------------------------------------
   logic signed [S:0]   x_ext, y_ext, x_mag_w, y_mag_w;
   logic [S-1:0]        x_mag, y_mag;
   vpa_pkg::side_type   side0_in, side0_ff;
   logic signed [CW-1:0] cx0_in, cy0_in, cx0_ff, cy0_ff;
   logic                valid0_ff;

   assign x_ext   = {req_payload.x_coord[S-1], req_payload.x_coord};
   assign y_ext   = {req_payload.y_coord[S-1], req_payload.y_coord};
   // one extra bit so the most negative input negates cleanly
   assign x_mag_w = x_ext[S] ? -x_ext : x_ext;
   assign y_mag_w = y_ext[S] ? -y_ext : y_ext;
   assign x_mag   = x_mag_w[S-1:0];
   assign y_mag   = y_mag_w[S-1:0];

   assign side0_in.x_neg    = req_payload.x_coord[S-1];
   assign side0_in.y_neg    = req_payload.y_coord[S-1];
   assign side0_in.vertical = CMPW_EXT(x_mag) <= CMPW_EXT_B(band_ff);

   assign cx0_in = $signed({2'b00, x_mag, {vpa_pkg::PRESHIFT{1'b0}}});
   assign cy0_in = $signed({2'b00, y_mag, {vpa_pkg::PRESHIFT{1'b0}}});

   function automatic logic [vpa_pkg::CMPW-1:0] CMPW_EXT(input logic [S-1:0] v);
      CMPW_EXT = vpa_pkg::CMPW'(v);
   endfunction

   function automatic logic [vpa_pkg::CMPW-1:0] CMPW_EXT_B(
      input logic [vpa_pkg::BAND_BITS-1:0] v);
      CMPW_EXT_B = vpa_pkg::CMPW'(v);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else begin
         valid0_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      cx0_ff   <= cx0_in;
      cy0_ff   <= cy0_in;
      side0_ff <= side0_in;
   end

   // ---------------------------------------------------------------
   // CORDIC vectoring pipeline, one rotation per stage
   // ---------------------------------------------------------------
   logic                 valid_pipe [N+1];
   logic signed [CW-1:0] cx_pipe    [N+1];
   logic signed [CW-1:0] cy_pipe    [N+1];
   logic signed [ZW-1:0] z_pipe     [N+1];
   vpa_pkg::side_type    side_pipe  [N+1];

   assign valid_pipe[0] = valid0_ff;
   assign cx_pipe[0]    = cx0_ff;
   assign cy_pipe[0]    = cy0_ff;
   assign z_pipe[0]     = '0;
   assign side_pipe[0]  = side0_ff;

   for (genvar i = 0; i < N; i++) begin : g_step
      vpa_cordic_stage #(
         .STEP (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_pipe[i]),
         .in_x      (cx_pipe[i]),
         .in_y      (cy_pipe[i]),
         .in_z      (z_pipe[i]),
         .in_side   (side_pipe[i]),
         .out_valid (valid_pipe[i+1]),
         .out_x     (cx_pipe[i+1]),
         .out_y     (cy_pipe[i+1]),
         .out_z     (z_pipe[i+1]),
         .out_side  (side_pipe[i+1])
      );
   end

   // ---------------------------------------------------------------
   // Saturate to [0, pi/2] and round half up to the output angle width
   // ---------------------------------------------------------------
   logic signed [ZW-1:0] z_last;
   logic [30:0]          t_sat;
   logic [31:0]          t_sum;
   logic [A-1:0]         t_round_in, t_round_ff;
   vpa_pkg::side_type    side_r_ff;
   logic                 valid_r_ff;

   assign z_last = z_pipe[N];

   always_comb begin
      if (z_last[ZW-1]) begin
         t_sat = '0;
      end else if (z_last > Z_MAX) begin
         t_sat = 31'(Z_MAX);
      end else begin
         t_sat = z_last[30:0];
      end
   end

   assign t_sum      = {1'b0, t_sat} + ROUND_HALF;
   assign t_round_in = t_sum[31:vpa_pkg::ROUND_DROP];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_r_ff <= 1'b0;
      end else begin
         valid_r_ff <= valid_pipe[N];
      end
   end

   always_ff @(posedge clock) begin
      t_round_ff <= t_round_in;
      side_r_ff  <= side_pipe[N];
   end

   // ---------------------------------------------------------------
   // Quadrant placement and half-circle fold; all sums wrap mod 2pi
   // ---------------------------------------------------------------
   logic [A-1:0]     full_in;
   vpa_pkg::rsp_type rsp_in, rsp_ff;
   logic             rsp_valid_ff;

   always_comb begin
      if (side_r_ff.vertical) begin
         full_in = side_r_ff.y_neg ? (HALF_TURN + QUARTER_TURN) : QUARTER_TURN;
      end else if (!side_r_ff.x_neg && !side_r_ff.y_neg) begin
         full_in = t_round_ff;
      end else if (side_r_ff.x_neg && !side_r_ff.y_neg) begin
         full_in = HALF_TURN - t_round_ff;
      end else if (side_r_ff.x_neg) begin
         full_in = HALF_TURN + t_round_ff;
      end else begin
         full_in = A'(0) - t_round_ff;
      end
   end

   // subtracting pi only clears the top bit
   assign rsp_in.full_angle  = full_in;
   assign rsp_in.orientation = full_in[A-2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_r_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/vpa_checker.sv
// vpa_checker: port-level assertions for vector_polar_angle, bound to the top.
// Depends on vpa_pkg and vector_polar_angle.
module vpa_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input vpa_pkg::req_type req_payload,
   input logic             rsp_valid,
   input vpa_pkg::rsp_type rsp_payload
);

   localparam int LAT = vpa_pkg::PIPE_LATENCY;
   localparam int S   = vpa_pkg::SAMPLE_BITS;
   localparam int A   = vpa_pkg::ANGLE_BITS;
   localparam logic [A-1:0] QUARTER_TURN = A'(64'd1 << (A - 2));
   localparam logic [A-1:0] HALF_TURN    = A'(64'd1 << (A - 1));

   logic accept;
   logic x_is_zero;

   assign accept    = start & ~busy;
   assign x_is_zero = req_payload.x_coord == '0;

   // every response traces back to an accepted request, checked against the pipeline latency
   a_rsp_has_request: assert property (@(posedge clock)
      rsp_valid |-> $past(accept, LAT))
      else $error("response without matching request");

   // the cycle after reset shows no response
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response strobe right after reset");

   // orientation is the full angle folded into the half circle
   a_fold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.orientation == rsp_payload.full_angle[A-2:0])
      else $error("orientation does not match full angle");

   // a vector on the y axis gives a quarter or three-quarter turn
   a_vertical: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(accept && x_is_zero, LAT) |->
         ($past(req_payload.y_coord[S-1], LAT) &&
            rsp_payload.full_angle == HALF_TURN + QUARTER_TURN) ||
         (!$past(req_payload.y_coord[S-1], LAT) &&
            rsp_payload.full_angle == QUARTER_TURN))
      else $error("vertical vector gave wrong angle");

endmodule

bind vector_polar_angle vpa_checker u_vpa_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);
